FILE: hw/rtl/agc_pkg.sv
`default_nettype none

package agc_pkg;

  // Fixed field widths of the request, result and configuration channels
  localparam int IN_W   = 32;
  localparam int PROF_W = 8;
  localparam int PEN_W  = 9;

  // Negative infinity sits this far above the most negative score
  localparam int NINF_OFFSET = 100;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_OPEN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_EXTEND = 1'd1;

  // Penalty reset values
  localparam logic signed [PEN_W-1:0] GAP_OPEN_RST   = -9'sd6;
  localparam logic signed [PEN_W-1:0] GAP_EXTEND_RST = -9'sd2;

  typedef struct packed {
    logic is_first;
    logic has_prev;
    logic last_cell;
  } agc_flags_t;

endpackage

`default_nettype wire

FILE: hw/rtl/agc_cell_datapath.sv
`default_nettype none

module agc_cell_datapath #(
  parameter int SCORE_BITS = 32,
  parameter int XW         = 34
) (
  input  wire logic signed [agc_pkg::IN_W-1:0]   diag_score,
  input  wire logic signed [agc_pkg::IN_W-1:0]   up_score,
  input  wire logic signed [agc_pkg::IN_W-1:0]   up_del_score,
  input  wire logic signed [agc_pkg::PROF_W-1:0] profile_score,
  input  wire logic signed [agc_pkg::IN_W-1:0]   cutoff_score,
  input  wire agc_pkg::agc_flags_t               flags,
  input  wire logic signed [agc_pkg::PEN_W-1:0]  open_pen,
  input  wire logic signed [agc_pkg::PEN_W-1:0]  ext_pen,
  input  wire logic signed [SCORE_BITS-1:0]      prior_match_best,
  input  wire logic signed [SCORE_BITS-1:0]      prior_ins,
  output logic signed [XW-1:0]                   best_x,
  output logic signed [XW-1:0]                   ins_x,
  output logic signed [XW-1:0]                   del_x,
  output logic signed [XW-1:0]                   pre_x
);
  import agc_pkg::*;

  localparam logic signed [XW-1:0] SMAX =
    {{(XW-SCORE_BITS+1){1'b0}}, {(SCORE_BITS-1){1'b1}}};
  localparam logic signed [XW-1:0] NINF_X = ~SMAX + XW'(NINF_OFFSET);

  function automatic logic signed [XW-1:0] clamp(input logic signed [XW-1:0] a);
    if (a < NINF_X) return NINF_X;
    if (a > SMAX) return SMAX;
    return a;
  endfunction

  function automatic logic signed [XW-1:0] max2(input logic signed [XW-1:0] a,
                                                input logic signed [XW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic signed [XW-1:0] diag, up, updel, cutoff, prof, go, ge, pmb, pins;
  logic signed [XW-1:0] match0, mt, e_open, e_ext;

  always_comb begin
    // Widen, then clamp the incoming scores into score range
    diag   = clamp({{(XW-IN_W){diag_score[IN_W-1]}}, diag_score});
    up     = clamp({{(XW-IN_W){up_score[IN_W-1]}}, up_score});
    updel  = clamp({{(XW-IN_W){up_del_score[IN_W-1]}}, up_del_score});
    cutoff = clamp({{(XW-IN_W){cutoff_score[IN_W-1]}}, cutoff_score});
    prof   = {{(XW-PROF_W){profile_score[PROF_W-1]}}, profile_score};
    go     = {{(XW-PEN_W){open_pen[PEN_W-1]}}, open_pen};
    ge     = {{(XW-PEN_W){ext_pen[PEN_W-1]}}, ext_pen};
    pmb    = {{(XW-SCORE_BITS){prior_match_best[SCORE_BITS-1]}}, prior_match_best};
    pins   = {{(XW-SCORE_BITS){prior_ins[SCORE_BITS-1]}}, prior_ins};

    match0 = flags.is_first ? NINF_X : clamp(diag + prof);
    del_x  = flags.has_prev ? max2(clamp(up + go), clamp(updel + ge)) : NINF_X;
    mt     = max2(del_x, match0);
    e_open = (flags.has_prev && !flags.is_first) ? clamp(pmb + go) : NINF_X;

    pre_x  = (mt >= cutoff) ? mt : NINF_X;
    e_ext  = flags.is_first ? NINF_X : clamp(pins + ge);
    ins_x  = max2(e_ext, e_open);
    best_x = (ins_x >= cutoff) ? max2(pre_x, ins_x) : pre_x;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/affine_gap_column_cell_update_unit.sv
// Path: each request passes the input register, then the result register.
// Throughput: one request per cycle while results drain; the only carried dependency is the
//   insertion and pre-insertion best of the previous cell, fed back from registers into the
//   next cell.
// Reset (rst, synchronous): request and result registers empty, gap open penalty -6,
//   gap extend penalty -2, carried cell state at negative infinity.
`default_nettype none

module affine_gap_column_cell_update_unit #(
  parameter int SCORE_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // request channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [agc_pkg::IN_W-1:0]    diag_score,
  input  wire logic signed [agc_pkg::IN_W-1:0]    up_score,
  input  wire logic signed [agc_pkg::IN_W-1:0]    up_del_score,
  input  wire logic signed [agc_pkg::PROF_W-1:0]  profile_score,
  input  wire logic signed [agc_pkg::IN_W-1:0]    cutoff_score,
  input  wire logic                               is_first,
  input  wire logic                               has_prev,
  input  wire logic                               last_cell,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [agc_pkg::IN_W-1:0]         new_best,
  output logic signed [agc_pkg::IN_W-1:0]         new_ins,
  output logic signed [agc_pkg::IN_W-1:0]         new_del,
  output logic                                    column_done,
  // configuration write port
  input  wire logic                               cfg_we,
  input  wire logic [agc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [agc_pkg::PEN_W-1:0]          cfg_data
);
  import agc_pkg::*;

  // Working width: room for a score plus a penalty or profile add without overflow
  localparam int XW = ((SCORE_BITS > IN_W) ? SCORE_BITS : IN_W) + 2;
  localparam logic signed [SCORE_BITS-1:0] NINF_S =
    {1'b1, {(SCORE_BITS-1){1'b0}}} + SCORE_BITS'(NINF_OFFSET);

  // Configuration registers
  logic signed [PEN_W-1:0] open_pen, ext_pen;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_pen <= GAP_OPEN_RST;
      ext_pen  <= GAP_EXTEND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAP_OPEN:   open_pen <= cfg_data;
        CFG_GAP_EXTEND: ext_pen  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register stage
  logic                     s1_valid;
  logic signed [IN_W-1:0]   s1_diag, s1_up, s1_updel, s1_cutoff;
  logic signed [PROF_W-1:0] s1_prof;
  agc_flags_t               s1_flags;

  logic in_accept, adv;

  // Advance the input stage whenever the result register is empty or being drained
  assign adv       = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Payload: hold while stalled, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_diag   <= diag_score;
      s1_up     <= up_score;
      s1_updel  <= up_del_score;
      s1_prof   <= profile_score;
      s1_cutoff <= cutoff_score;
      s1_flags  <= '{is_first: is_first, has_prev: has_prev, last_cell: last_cell};
    end
  end

  // Carried state between cells of one column
  logic signed [SCORE_BITS-1:0] prior_match_best, prior_ins;
  logic signed [XW-1:0]         best_x, ins_x, del_x, pre_x;

  agc_cell_datapath #(
    .SCORE_BITS (SCORE_BITS),
    .XW         (XW)
  ) u_datapath (
    .diag_score       (s1_diag),
    .up_score         (s1_up),
    .up_del_score     (s1_updel),
    .profile_score    (s1_prof),
    .cutoff_score     (s1_cutoff),
    .flags            (s1_flags),
    .open_pen         (open_pen),
    .ext_pen          (ext_pen),
    .prior_match_best (prior_match_best),
    .prior_ins        (prior_ins),
    .best_x           (best_x),
    .ins_x            (ins_x),
    .del_x            (del_x),
    .pre_x            (pre_x)
  );

  // Update the carried state as the cell leaves the input stage; drop it at column end
  always_ff @(posedge clk) begin
    if (rst) begin
      prior_match_best <= NINF_S;
      prior_ins        <= NINF_S;
    end else if (adv) begin
      if (s1_flags.last_cell) begin
        prior_match_best <= NINF_S;
        prior_ins        <= NINF_S;
      end else begin
        prior_match_best <= pre_x[SCORE_BITS-1:0];
        prior_ins        <= ins_x[SCORE_BITS-1:0];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Results carry the low 32 bits of the (already sign-extended) score
  always_ff @(posedge clk) begin
    if (adv) begin
      new_best    <= best_x[IN_W-1:0];
      new_ins     <= ins_x[IN_W-1:0];
      new_del     <= del_x[IN_W-1:0];
      column_done <= s1_flags.last_cell;
    end
  end

  // Column end clears the carried state
  a_col_end_clear: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_flags.last_cell) |=> (prior_match_best == NINF_S && prior_ins == NINF_S))
    else $error("carried state not cleared after last cell");

  // Carried state never drops below negative infinity
  a_state_floor: assert property (@(posedge clk) disable iff (rst)
    (prior_match_best >= NINF_S && prior_ins >= NINF_S))
    else $error("carried state below negative infinity");

  // Backpressure only when both stages are full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("request stalled with a free stage");

  // A result is never dropped while stalled
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result lost");

endmodule

`default_nettype wire
